/* hw/rtl/crc8wf_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the word frame checker.
package crc8wf_pkg;

    localparam int MAX_VALUES = 16;
    localparam int VALUE_CAP  = (MAX_VALUES < 16) ? MAX_VALUES : 16;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam int VPF_W = 5;
    localparam int WPV_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [VPF_W-1:0] VPF_RESET = 5'd10;
    localparam logic [WPV_W-1:0] WPV_RESET = 2'd2;
    localparam logic [VPF_W-1:0] VPF_CAP   = VPF_W'(VALUE_CAP);

    localparam logic REG_VALUES_PER_FRAME = 1'b0;
    localparam logic REG_WORDS_PER_VALUE  = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  value_index;
        logic        crc_error;
        logic        last;
    } result_t;

    // MSB-first CRC-8 over one byte, no final XOR
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/crc8wf_front.sv */
// Front end: per-byte CRC check, word assembly and result classification.
module crc8wf_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [7:0]                      rx_byte,
    input  logic                            frame_start,
    input  logic [crc8wf_pkg::VPF_W-1:0]    values_per_frame,
    input  logic [crc8wf_pkg::WPV_W-1:0]    words_per_value,
    output logic                            res_valid,
    output crc8wf_pkg::result_t             res
);
    import crc8wf_pkg::*;

    logic [7:0]  crc_reg, crc_next, crc_s;
    logic [1:0]  big_reg, big_next, big_s;
    logic        wiv_reg, wiv_next, wiv_s;
    logic [31:0] pv_reg, pv_next, pv_s;
    logic [3:0]  vc_reg, vc_next, vc_s;
    logic        disc_reg, disc_next, disc_s;
    logic [VPF_W-1:0] eff_values;
    logic        is_last;

    always_comb
    begin
        if (values_per_frame == '0)
            eff_values = VPF_W'(1);
        else if (values_per_frame > VPF_CAP)
            eff_values = VPF_CAP;
        else
            eff_values = values_per_frame;
    end

    // frame start clears the frame state before the byte is handled
    assign crc_s  = frame_start ? CRC_INIT : crc_reg;
    assign big_s  = frame_start ? 2'd0     : big_reg;
    assign wiv_s  = frame_start ? 1'b0     : wiv_reg;
    assign pv_s   = frame_start ? 32'd0    : pv_reg;
    assign vc_s   = frame_start ? 4'd0     : vc_reg;
    assign disc_s = frame_start ? 1'b0     : disc_reg;

    assign is_last = ({1'b0, vc_s} + VPF_W'(1)) >= eff_values;

    always_comb
    begin
        crc_next  = crc_reg;
        big_next  = big_reg;
        wiv_next  = wiv_reg;
        pv_next   = pv_reg;
        vc_next   = vc_reg;
        disc_next = disc_reg;
        res_valid = 1'b0;
        res       = '0;
        if (accept)
        begin
            crc_next  = crc_s;
            big_next  = big_s;
            wiv_next  = wiv_s;
            pv_next   = pv_s;
            vc_next   = vc_s;
            disc_next = disc_s;
            if (!disc_s)
            begin
                if (!big_s[1])
                begin
                    crc_next = crc8_byte(crc_s, rx_byte);
                    pv_next  = {pv_s[23:0], rx_byte};
                    big_next = big_s + 2'd1;
                end
                else
                begin
                    big_next = 2'd0;
                    crc_next = CRC_INIT;
                    if (rx_byte != crc_s)
                    begin
                        res_valid       = 1'b1;
                        res.value       = 32'd0;
                        res.value_index = vc_s;
                        res.crc_error   = 1'b1;
                        res.last        = 1'b1;
                        disc_next       = 1'b1;
                    end
                    else if (!wiv_s && words_per_value[1])
                    begin
                        wiv_next = 1'b1;
                    end
                    else
                    begin
                        res_valid       = 1'b1;
                        res.value       = pv_s;
                        res.value_index = vc_s;
                        res.crc_error   = 1'b0;
                        res.last        = is_last;
                        pv_next         = 32'd0;
                        wiv_next        = 1'b0;
                        if (is_last)
                        begin
                            vc_next   = 4'd0;
                            disc_next = 1'b1;
                        end
                        else
                        begin
                            vc_next = vc_s + 4'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            big_reg  <= 2'd0;
            wiv_reg  <= 1'b0;
            pv_reg   <= 32'd0;
            vc_reg   <= 4'd0;
            disc_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            big_reg  <= big_next;
            wiv_reg  <= wiv_next;
            pv_reg   <= pv_next;
            vc_reg   <= vc_next;
            disc_reg <= disc_next;
        end
    end

endmodule

/* hw/rtl/crc8wf_fifo.sv */
// Short result queue between the byte front end and the result port.
module crc8wf_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    input  crc8wf_pkg::result_t wr_data,
    input  logic                rd_pop,
    output logic                full,
    output logic                empty,
    output crc8wf_pkg::result_t rd_data
);
    import crc8wf_pkg::*;

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_valid && !full;
    assign do_rd   = rd_pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(do_wr) - (FIFO_AW+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/crc8_word_frame_checker.sv */
// Top level: CRC-8 checked word framing of a sensor reply byte stream.
//
// Input side is a queue write: a byte request (rx_byte, frame_start) is taken
// at a clock edge with push high and full low. One byte can be taken every
// cycle while full is low. Results come out of a queue: while empty is low the
// oldest result sits on value/value_index/crc_error/last and pop takes it.
// A result is written into the queue at the clock edge that takes the CRC
// byte that produces it. The byte front end handles one byte per cycle; its only
// limit is the 4-entry result queue: full rises when four results wait, so a
// stalled receiver holds off the byte source without losing anything.
// Configuration: wr_en/wr_index/wr_data write values_per_frame (index 0) or
// words_per_value (index 1); write only while the block is idle.
// Reset clears the queue, sets the registers to 10 values of 2 words, and
// puts the frame state as after a frame start (CRC 0xFF, counters zero).
module crc8_word_frame_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        rx_byte,
    input  logic                              frame_start,
    output logic                              empty,
    input  logic                              pop,
    output logic [31:0]                       value,
    output logic [3:0]                        value_index,
    output logic                              crc_error,
    output logic                              last,
    input  logic                              wr_en,
    input  logic                              wr_index,
    input  logic [crc8wf_pkg::CFG_DATA_W-1:0] wr_data
);
    import crc8wf_pkg::*;

    logic [VPF_W-1:0] vpf_reg, vpf_next;
    logic [WPV_W-1:0] wpv_reg, wpv_next;
    logic             accept;
    logic             res_valid;
    result_t          res;
    result_t          head;

    always_comb
    begin
        vpf_next = vpf_reg;
        wpv_next = wpv_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_VALUES_PER_FRAME: vpf_next = wr_data[VPF_W-1:0];
                REG_WORDS_PER_VALUE:  wpv_next = wr_data[WPV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpf_reg <= VPF_RESET;
            wpv_reg <= WPV_RESET;
        end
        else
        begin
            vpf_reg <= vpf_next;
            wpv_reg <= wpv_next;
        end
    end

    assign accept = push && !full;

    crc8wf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .rx_byte          (rx_byte),
        .frame_start      (frame_start),
        .values_per_frame (vpf_reg),
        .words_per_value  (wpv_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    crc8wf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .rd_pop   (pop),
        .full     (full),
        .empty    (empty),
        .rd_data  (head)
    );

    assign value       = head.value;
    assign value_index = head.value_index;
    assign crc_error   = head.crc_error;
    assign last        = head.last;

    // a result only comes from an accepted byte, and never overflows the queue
    a_res_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> accept)
        else $error("result produced without an accepted byte");

    a_res_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !pop) |-> !full)
        else $error("result pushed into a full queue");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && crc_error) |-> (last && value == 32'd0))
        else $error("error result must be last with zero value");

endmodule

/* tb/tb.sv */
// Testbench for crc8_word_frame_checker: directed, back-pressure and random frame traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crc8wf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;
    localparam int HOLD_CYCLES  = 200;

    typedef enum int {FR_CLEAN, FR_TAIL, FR_BAD_CRC, FR_CUT, FR_NOISE} frame_kind_e;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  push        = 1'b0;
    logic [7:0]            rx_byte     = 8'h00;
    logic                  frame_start = 1'b0;
    logic                  pop         = 1'b0;
    logic                  wr_en       = 1'b0;
    logic                  wr_index    = 1'b0;
    logic [CFG_DATA_W-1:0] wr_data     = '0;
    logic                  full;
    logic                  empty;
    logic [31:0]           value;
    logic [3:0]            value_index;
    logic                  crc_error;
    logic                  last;

    crc8_word_frame_checker DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .empty       (empty),
        .pop         (pop),
        .value       (value),
        .value_index (value_index),
        .crc_error   (crc_error),
        .last        (last),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    always #1 clk = ~clk;

    // shadow of the block's registers and frame state
    logic [VPF_W-1:0] vpf_cfg = VPF_RESET;
    logic [WPV_W-1:0] wpv_cfg = WPV_RESET;
    logic [7:0]       crc_acc;
    logic [1:0]       grp_pos;
    logic             word_pos;
    logic [31:0]      val_acc;
    logic [3:0]       val_pos;
    logic             skipping;

    result_t expected_q[$];

    int   errors         = 0;
    int   cycles         = 0;
    int   sent_bytes     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic holding        = 1'b0;
    event hold_go;

    // bitwise MSB-first CRC-8, fed one data bit at a time
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic int vals_in_frame();
        int v;
        v = int'(vpf_cfg);
        if (v < 1)
            v = 1;
        if (v > VALUE_CAP)
            v = VALUE_CAP;
        return v;
    endfunction

    function automatic int words_in_value();
        if (wpv_cfg == 2'd0)
            return 1;
        if (wpv_cfg == 2'd3)
            return 2;
        return int'(wpv_cfg);
    endfunction

    function automatic void clear_frame_state();
        crc_acc  = CRC_INIT;
        grp_pos  = 2'd0;
        word_pos = 1'b0;
        val_acc  = 32'h0;
        val_pos  = 4'd0;
        skipping = 1'b0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic fs);
        result_t r;
        logic    is_last;
        if (fs)
            clear_frame_state();
        if (skipping)
            return;
        if (grp_pos < 2'd2) begin
            crc_acc = crc8_next(crc_acc, b);
            val_acc = {val_acc[23:0], b};
            grp_pos = grp_pos + 2'd1;
            return;
        end
        grp_pos = 2'd0;
        if (b != crc_acc) begin
            crc_acc       = CRC_INIT;
            r.value       = 32'h0;
            r.value_index = val_pos;
            r.crc_error   = 1'b1;
            r.last        = 1'b1;
            expected_q.push_back(r);
            skipping = 1'b1;
            return;
        end
        crc_acc = CRC_INIT;
        if (int'(word_pos) + 1 < words_in_value()) begin
            word_pos = 1'b1;
            return;
        end
        is_last       = (int'(val_pos) + 1 >= vals_in_frame());
        r.value       = val_acc;
        r.value_index = val_pos;
        r.crc_error   = 1'b0;
        r.last        = is_last;
        expected_q.push_back(r);
        val_acc  = 32'h0;
        word_pos = 1'b0;
        if (is_last) begin
            val_pos  = 4'd0;
            skipping = 1'b1;
        end else begin
            val_pos = val_pos + 4'd1;
        end
    endfunction

    task automatic report(input string what);
        errors++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // result checker
    always @(posedge clk) begin : check_result
        result_t want;
        if (rst_n && pop && !empty) begin
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result value=%h index=%0d err=%b last=%b",
                                 value, value_index, crc_error, last));
            end else begin
                want = expected_q.pop_front();
                if (value !== want.value)
                    report($sformatf("value %h, want %h", value, want.value));
                if (value_index !== want.value_index)
                    report($sformatf("value_index %0d, want %0d", value_index, want.value_index));
                if (crc_error !== want.crc_error)
                    report($sformatf("crc_error %b, want %b", crc_error, want.crc_error));
                if (last !== want.last)
                    report($sformatf("last %b, want %b", last, want.last));
            end
        end
    end

    // long receiver hold-off, counted here
    always begin
        @(hold_go);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    always @(negedge clk)
        pop <= !holding && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("crc8_word_frame_checker: mismatch");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            push <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        push        <= 1'b1;
        rx_byte     <= b;
        frame_start <= fs;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_byte(b, fs);
        sent_bytes++;
    endtask

    task automatic send_word(input logic [7:0] hi, input logic [7:0] lo, input logic fs,
                             input logic corrupt);
        logic [7:0] c;
        c = crc8_next(crc8_next(CRC_INIT, hi), lo);
        if (corrupt)
            c = c ^ 8'($urandom_range(255, 1));
        send_byte(hi, fs);
        send_byte(lo, 1'b0);
        send_byte(c, 1'b0);
    endtask

    // sender pauses until every result is out and the pipeline has settled
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        if (idx == REG_VALUES_PER_FRAME)
            vpf_cfg = data[VPF_W-1:0];
        else
            wpv_cfg = data[WPV_W-1:0];
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(19))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame(input frame_kind_e kind);
        int   total;
        int   stop_at;
        int   bad_at;
        logic first;
        total   = vals_in_frame() * words_in_value();
        stop_at = (kind == FR_CUT) ? $urandom_range(total - 1) : total;
        bad_at  = (kind == FR_BAD_CRC) ? $urandom_range(total - 1) : -1;
        first   = 1'b1;
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(8, 1))
                send_byte(rand_byte(), $urandom_range(7) == 0);
            return;
        end
        for (int g = 0; g < stop_at; g++) begin
            send_word(rand_byte(), rand_byte(), first, g == bad_at);
            first = 1'b0;
            if (g == bad_at)
                break;
        end
        case (kind)
            FR_CUT: begin
                repeat ($urandom_range(2)) begin
                    send_byte(rand_byte(), first);
                    first = 1'b0;
                end
            end
            FR_TAIL, FR_BAD_CRC: begin
                // bytes past the end or past a bad CRC are dropped
                repeat ($urandom_range(3))
                    send_byte(rand_byte(), 1'b0);
            end
            default: ;
        endcase
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // no frame start yet: framing runs as if one came with reset
        send_word(8'h00, 8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 8'hFF, 1'b0, 1'b0);
        send_word(8'hAA, 8'h55, 1'b0, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_word(8'h01, 8'h02, 1'b1, 1'b0);
        // restart in the middle of a value
        send_word(8'h80, 8'h7F, 1'b1, 1'b0);
        drain();
        // shrink to one word with a word already held: value goes out at next word
        write_reg(REG_WORDS_PER_VALUE, CFG_DATA_W'(1));
        send_word(8'hAB, 8'hCD, 1'b0, 1'b0);
        drain();
        write_reg(REG_VALUES_PER_FRAME, CFG_DATA_W'(1));
        send_word(8'hFF, 8'hFF, 1'b1, 1'b0);
        send_byte(8'h5A, 1'b0);
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_VALUES_PER_FRAME, CFG_DATA_W'(16));
        write_reg(REG_WORDS_PER_VALUE, CFG_DATA_W'(1));
        -> hold_go;
        send_frame(FR_CLEAN);
        drain();
        send_frame(FR_CLEAN);
        drain();
    endtask

    task automatic test_random(input int n_bytes, input int idle_pct, input int stall_pct);
        int target;
        int r;
        logic [CFG_DATA_W-1:0] vpf;
        frame_kind_e kind;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = sent_bytes + n_bytes;
        while (sent_bytes < target) begin
            drain();
            r = $urandom_range(99);
            if (r < 10)
                vpf = CFG_DATA_W'(0);
            else if (r < 20)
                vpf = CFG_DATA_W'(31);
            else if (r < 30)
                vpf = CFG_DATA_W'(16);
            else if (r < 35)
                vpf = CFG_DATA_W'($urandom_range(30, 17));
            else
                vpf = CFG_DATA_W'($urandom_range(6, 1));
            write_reg(REG_VALUES_PER_FRAME, vpf);
            write_reg(REG_WORDS_PER_VALUE, CFG_DATA_W'($urandom_range(3)));
            repeat ($urandom_range(4, 1)) begin
                r = $urandom_range(99);
                if (r < 60)
                    kind = FR_CLEAN;
                else if (r < 72)
                    kind = FR_TAIL;
                else if (r < 84)
                    kind = FR_BAD_CRC;
                else if (r < 94)
                    kind = FR_CUT;
                else
                    kind = FR_NOISE;
                send_frame(kind);
            end
        end
        drain();
    endtask

    initial begin
        clear_frame_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random(320, 0, 0);
        test_random(320, 72, 0);
        test_random(320, 0, 72);
        test_random(320, 6, 6);

        recv_stall_pct = 0;
        drain();
        if (errors == 0)
            $display("crc8_word_frame_checker: match");
        else
            $display("crc8_word_frame_checker: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/crc8wf_pkg.sv
hw/rtl/crc8wf_front.sv
hw/rtl/crc8wf_fifo.sv
hw/rtl/crc8_word_frame_checker.sv
tb/tb.sv
